### rtl/core/dmpi_pkg.sv
// Shared types, widths and constants for the dual-motor PI speed loop.
// Holds the microcode program table used by the sequencer.
// No dependencies.
package dmpi_pkg;

   // payload field widths
   localparam int IN_COUNT_W = 32;
   localparam int TARGET_W   = 16;
   localparam int BASE_W     = 13;
   localparam int MAG_W      = 13;
   localparam int SPEED_W    = 16;

   // register widths
   localparam int SCALE_W  = 32;
   localparam int ALPHA_W  = 17;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 12;
   localparam int DBAND_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // datapath widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int RAW_W  = 32;
   localparam int FILT_W = 32;
   localparam int ERR_W  = 18;
   localparam int OUT_W  = 13;
   localparam int DRV_W  = 14;
   localparam int STEP_W = 4;

   localparam logic signed [RAW_W-1:0] RAW_LIMIT = 32'sh7FFF_0000;
   localparam logic [ALPHA_W-1:0]      ALPHA_ONE = 17'h1_0000;

   localparam logic WHEEL_A = 1'b0;
   localparam logic WHEEL_B = 1'b1;

   // register reset values
   localparam logic [SCALE_W-1:0]        RST_SPEED_SCALE  = 32'd65536;
   localparam logic [ALPHA_W-1:0]        RST_FILTER_ALPHA = 17'd13107;
   localparam logic signed [GAIN_W-1:0]  RST_DIFF_GAIN_A  = 16'sd1792;
   localparam logic signed [GAIN_W-1:0]  RST_ERR_GAIN_A   = 16'sd0;
   localparam logic signed [GAIN_W-1:0]  RST_DIFF_GAIN_B  = 16'sd1920;
   localparam logic signed [GAIN_W-1:0]  RST_ERR_GAIN_B   = 16'sd0;
   localparam logic [LIMIT_W-1:0]        RST_OUTPUT_LIMIT = 12'd1220;
   localparam logic [DBAND_W-1:0]        RST_DEADBAND     = 8'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_SCALE  = 3'd0,
      CSR_FILTER_ALPHA = 3'd1,
      CSR_DIFF_GAIN_A  = 3'd2,
      CSR_ERR_GAIN_A   = 3'd3,
      CSR_DIFF_GAIN_B  = 3'd4,
      CSR_ERR_GAIN_B   = 3'd5,
      CSR_OUTPUT_LIMIT = 3'd6,
      CSR_DEADBAND     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]       speed_scale;
      logic [ALPHA_W-1:0]       filter_alpha;
      logic signed [GAIN_W-1:0] diff_gain_a;
      logic signed [GAIN_W-1:0] err_gain_a;
      logic signed [GAIN_W-1:0] diff_gain_b;
      logic signed [GAIN_W-1:0] err_gain_b;
      logic [LIMIT_W-1:0]       output_limit;
      logic [DBAND_W-1:0]       target_deadband;
   } cfg_type;

   typedef struct packed {
      logic signed [IN_COUNT_W-1:0] count_a;
      logic signed [IN_COUNT_W-1:0] count_b;
      logic signed [TARGET_W-1:0]   target_speed;
      logic signed [BASE_W-1:0]     base_drive;
      logic                         mode;
   } req_data_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_DIFF,
      OP_SAT,
      OP_LOAD_PROD,
      OP_ADD_PROD,
      OP_FILT_STORE,
      OP_ERROR,
      OP_PERR,
      OP_INC_SCALE,
      OP_ACC_CLAMP,
      OP_ACC_OUT,
      OP_DRIVE
   } op_type;

   typedef enum logic [2:0] {
      MS_NONE,
      MS_SCALE,
      MS_FILT_OLD,
      MS_FILT_NEW,
      MS_DIFF,
      MS_ERR
   } mul_src_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_WAIT_REQ,
      JC_LOOP_WHEEL,
      JC_WAIT_OUT
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_IDLE      = 4'd0;
   localparam step_type ST_DIFF      = 4'd1;
   localparam step_type ST_MUL_SCALE = 4'd2;
   localparam step_type ST_SAT       = 4'd3;
   localparam step_type ST_MUL_NEW   = 4'd4;
   localparam step_type ST_FSUM      = 4'd5;
   localparam step_type ST_FSTORE    = 4'd6;
   localparam step_type ST_ERROR     = 4'd7;
   localparam step_type ST_MUL_DIFF  = 4'd8;
   localparam step_type ST_MUL_ERR   = 4'd9;
   localparam step_type ST_ISUM      = 4'd10;
   localparam step_type ST_ISCALE    = 4'd11;
   localparam step_type ST_ACC       = 4'd12;
   localparam step_type ST_ACC_OUT   = 4'd13;
   localparam step_type ST_DRIVE     = 4'd14;
   localparam step_type ST_LAST      = ST_DRIVE;

   typedef struct packed {
      op_type      op;
      mul_src_type mul_src;
      cond_type    cond;
      step_type    target;
   } uword_type;

   typedef struct packed {
      op_type      op;
      mul_src_type mul_src;
      logic        wheel;
      logic        accept;
   } ctl_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // Microcode program. Steps 1..13 run once per wheel; the multiplier
   // result of a step is consumed by the following step.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         ST_IDLE:      w = '{OP_NOP,        MS_NONE,     JC_WAIT_REQ,   ST_IDLE};
         ST_DIFF:      w = '{OP_DIFF,       MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_MUL_SCALE: w = '{OP_NOP,        MS_SCALE,    JC_NEXT,       ST_IDLE};
         ST_SAT:       w = '{OP_SAT,        MS_FILT_OLD, JC_NEXT,       ST_IDLE};
         ST_MUL_NEW:   w = '{OP_LOAD_PROD,  MS_FILT_NEW, JC_NEXT,       ST_IDLE};
         ST_FSUM:      w = '{OP_ADD_PROD,   MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_FSTORE:    w = '{OP_FILT_STORE, MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_ERROR:     w = '{OP_ERROR,      MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_MUL_DIFF:  w = '{OP_PERR,       MS_DIFF,     JC_NEXT,       ST_IDLE};
         ST_MUL_ERR:   w = '{OP_LOAD_PROD,  MS_ERR,      JC_NEXT,       ST_IDLE};
         ST_ISUM:      w = '{OP_ADD_PROD,   MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_ISCALE:    w = '{OP_INC_SCALE,  MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_ACC:       w = '{OP_ACC_CLAMP,  MS_NONE,     JC_NEXT,       ST_IDLE};
         ST_ACC_OUT:   w = '{OP_ACC_OUT,    MS_NONE,     JC_LOOP_WHEEL, ST_DIFF};
         ST_DRIVE:     w = '{OP_DRIVE,      MS_NONE,     JC_WAIT_OUT,   ST_IDLE};
         default:      w = '{OP_NOP,        MS_NONE,     JC_NEXT,       ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/dmpi_if.sv
// Valid/ready channel interfaces: request, response and register write port.
// Depends on dmpi_pkg.
interface dmpi_req_if;
   import dmpi_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [IN_COUNT_W-1:0] count_a;
   logic signed [IN_COUNT_W-1:0] count_b;
   logic signed [TARGET_W-1:0]   target_speed;
   logic signed [BASE_W-1:0]     base_drive;
   logic                         mode;
   modport source (output valid, count_a, count_b, target_speed, base_drive, mode,
                   input ready);
   modport sink   (input valid, count_a, count_b, target_speed, base_drive, mode,
                   output ready);
endinterface

interface dmpi_rsp_if;
   import dmpi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      dir_left;
   logic [MAG_W-1:0]          mag_left;
   logic                      dir_right;
   logic [MAG_W-1:0]          mag_right;
   logic signed [SPEED_W-1:0] speed_a_now;
   logic signed [SPEED_W-1:0] speed_b_now;
   modport source (output valid, dir_left, mag_left, dir_right, mag_right,
                   speed_a_now, speed_b_now, input ready);
   modport sink   (input valid, dir_left, mag_left, dir_right, mag_right,
                   speed_a_now, speed_b_now, output ready);
endinterface

interface dmpi_csr_if;
   import dmpi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/dmpi_csr.sv
// Configuration register file, written through the register write port.
// Depends on dmpi_pkg and dmpi_if.
module dmpi_csr (
   input  logic              clock,
   input  logic              reset,
   dmpi_csr_if.sink          csr_if,
   output dmpi_pkg::cfg_type cfg
);
   import dmpi_pkg::*;

   cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale     <= RST_SPEED_SCALE;
         cfg_ff.filter_alpha    <= RST_FILTER_ALPHA;
         cfg_ff.diff_gain_a     <= RST_DIFF_GAIN_A;
         cfg_ff.err_gain_a      <= RST_ERR_GAIN_A;
         cfg_ff.diff_gain_b     <= RST_DIFF_GAIN_B;
         cfg_ff.err_gain_b      <= RST_ERR_GAIN_B;
         cfg_ff.output_limit    <= RST_OUTPUT_LIMIT;
         cfg_ff.target_deadband <= RST_DEADBAND;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_SPEED_SCALE:  cfg_ff.speed_scale     <= csr_if.data[SCALE_W-1:0];
            CSR_FILTER_ALPHA: cfg_ff.filter_alpha    <= csr_if.data[ALPHA_W-1:0];
            CSR_DIFF_GAIN_A:  cfg_ff.diff_gain_a     <= $signed(csr_if.data[GAIN_W-1:0]);
            CSR_ERR_GAIN_A:   cfg_ff.err_gain_a      <= $signed(csr_if.data[GAIN_W-1:0]);
            CSR_DIFF_GAIN_B:  cfg_ff.diff_gain_b     <= $signed(csr_if.data[GAIN_W-1:0]);
            CSR_ERR_GAIN_B:   cfg_ff.err_gain_b      <= $signed(csr_if.data[GAIN_W-1:0]);
            CSR_OUTPUT_LIMIT: cfg_ff.output_limit    <= csr_if.data[LIMIT_W-1:0];
            CSR_DEADBAND:     cfg_ff.target_deadband <= csr_if.data[DBAND_W-1:0];
         endcase
      end
   end

endmodule

### rtl/core/dmpi_seq.sv
// Microcode sequencer: step counter, program table lookup, conditional jumps
// and the wheel select. Depends on dmpi_pkg.
module dmpi_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  dmpi_pkg::stat_type stat,
   output logic               req_ready,
   output dmpi_pkg::ctl_type  ctl
);
   import dmpi_pkg::*;

   step_type  step_ff, step_in;
   logic      wheel_ff, wheel_in;
   uword_type uword;
   logic      accept;

   assign uword     = ucode_rom(step_ff);
   assign req_ready = (uword.cond == JC_WAIT_REQ);
   assign accept    = req_ready && req_valid;

   assign ctl.op      = uword.op;
   assign ctl.mul_src = uword.mul_src;
   assign ctl.wheel   = wheel_ff;
   assign ctl.accept  = accept;

   always_comb begin
      step_in  = step_ff + 1'b1;
      wheel_in = wheel_ff;
      unique case (uword.cond)
         JC_NEXT: ;
         JC_WAIT_REQ: begin
            if (!req_valid) step_in = step_ff;
         end
         JC_LOOP_WHEEL: begin
            // wheel A done: rerun the wheel program for B
            if (wheel_ff == WHEEL_A) begin
               step_in  = uword.target;
               wheel_in = WHEEL_B;
            end else begin
               wheel_in = WHEEL_A;
            end
         end
         JC_WAIT_OUT: begin
            step_in = stat.out_free ? uword.target : step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         wheel_ff <= WHEEL_A;
      end else begin
         step_ff  <= step_in;
         wheel_ff <= wheel_in;
      end
   end

`ifndef NO_ASSERTIONS
   ap_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == ST_DIFF && wheel_ff == WHEEL_A))
      else $error("accepted word did not start the wheel A program");

   ap_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_LAST)
      else $error("step counter left the program");

   ap_drive_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_DRIVE && !stat.out_free) |=> step_ff == ST_DRIVE)
      else $error("drive step left while the response register was full");
`endif

endmodule

### rtl/core/dmpi_datapath.sv
// Datapath driven by the microcode word: shared 33x33 multiplier with a
// registered product, sum register, per-wheel state and the response register.
// Depends on dmpi_pkg and dmpi_if.
module dmpi_datapath #(
   parameter int COUNT_WIDTH   = 32,
   parameter int ACC_FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dmpi_pkg::cfg_type      cfg,
   input  dmpi_pkg::ctl_type      ctl,
   input  dmpi_pkg::req_data_type req_data,
   output dmpi_pkg::stat_type     stat,
   dmpi_rsp_if.source             rsp_if
);
   import dmpi_pkg::*;

   localparam int SH     = ACC_FRAC_BITS - 8;
   localparam int PSH    = (SH > 0) ? SH : 0;
   localparam int NSH    = (SH < 0) ? -SH : 1;
   localparam int INC_W  = 36 + PSH;
   localparam int SUM_W  = (INC_W > 49) ? INC_W : 49;
   localparam int ACC_W  = LIMIT_W + ACC_FRAC_BITS + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam logic signed [PROD_W-1:0] PROD_LIM = PROD_W'(RAW_LIMIT);

   // latched request
   logic [COUNT_WIDTH-1:0]     count_ff [2];
   logic signed [TARGET_W-1:0] target_ff;
   logic signed [BASE_W-1:0]   base_ff;
   logic                       mode_ff;

   // per-wheel state
   logic [COUNT_WIDTH-1:0]       prev_ff  [2];
   logic signed [FILT_W-1:0]     filt_ff  [2];
   logic signed [ERR_W-1:0]      perr_ff  [2];
   logic signed [ACC_W-1:0]      acc_ff   [2];
   logic signed [SPEED_W-1:0]    speed_ff [2];
   logic signed [OUT_W-1:0]      out_ff   [2];

   // work registers
   logic signed [COUNT_WIDTH-1:0] delta_ff, delta_in;
   logic signed [RAW_W-1:0]       raw_ff, raw_in;
   logic signed [ERR_W-1:0]       err_ff, err_in;
   logic signed [PROD_W-1:0]      product_ff, product_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;

   // response register
   logic                      rsp_valid_ff;
   logic                      dir_left_ff, dir_right_ff;
   logic [MAG_W-1:0]          mag_left_ff, mag_right_ff;
   logic signed [SPEED_W-1:0] speed_a_ff, speed_b_ff;

   logic                      w;
   logic [ALPHA_W-1:0]        alpha_c, alpha_rest;
   logic signed [DIFF_W-1:0]  err_diff;
   logic signed [GAIN_W-1:0]  gain_diff, gain_err;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [FILT_W-1:0]  filt_in, fq;
   logic signed [SUM_W-1:0]   sq, inc_scaled;
   logic signed [SPEED_W-1:0] speed_in;
   logic signed [ACC_W-1:0]   lim_acc, acc_in, aq;
   logic signed [SUM_W:0]     acc_sum, lim_ext;
   logic signed [OUT_W-1:0]   out_in;
   logic signed [TARGET_W:0]  tgt_ext;
   logic [TARGET_W:0]         tgt_abs;
   logic signed [TARGET_W-1:0] target_in;
   logic signed [DRV_W-1:0]   left_in, right_in;
   logic                      dir_left_in, dir_right_in;
   logic [MAG_W-1:0]          mag_left_in, mag_right_in;

   assign w = ctl.wheel;
   assign stat.out_free = !rsp_valid_ff || rsp_if.ready;

   // deadband applies in base mode only
   always_comb begin
      tgt_ext   = (TARGET_W+1)'(req_data.target_speed);
      tgt_abs   = (tgt_ext < 0) ? -tgt_ext : tgt_ext;
      target_in = req_data.target_speed;
      if (req_data.mode && (tgt_abs < (TARGET_W+1)'(cfg.target_deadband)))
         target_in = '0;
   end

   assign delta_in   = $signed(count_ff[w] - prev_ff[w]);
   assign alpha_c    = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
   assign alpha_rest = ALPHA_ONE - alpha_c;
   assign err_diff   = DIFF_W'(err_ff) - DIFF_W'(perr_ff[w]);
   assign gain_diff  = (w == WHEEL_B) ? cfg.diff_gain_b : cfg.diff_gain_a;
   assign gain_err   = (w == WHEEL_B) ? cfg.err_gain_b : cfg.err_gain_a;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.mul_src)
         MS_NONE: ;
         MS_SCALE: begin
            mul_a = MUL_W'(delta_ff);
            mul_b = MUL_W'(cfg.speed_scale);
         end
         MS_FILT_OLD: begin
            mul_a = MUL_W'(filt_ff[w]);
            mul_b = MUL_W'(alpha_rest);
         end
         MS_FILT_NEW: begin
            mul_a = MUL_W'(raw_ff);
            mul_b = MUL_W'(alpha_c);
         end
         MS_DIFF: begin
            mul_a = MUL_W'(err_diff);
            mul_b = MUL_W'(gain_diff);
         end
         MS_ERR: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'(gain_err);
         end
         default: ;
      endcase
   end

   assign product_in = mul_a * mul_b;

   // symmetric saturation of the scaled count difference
   always_comb begin
      if (product_ff > PROD_LIM)
         raw_in = RAW_LIMIT;
      else if (product_ff < -PROD_LIM)
         raw_in = -RAW_LIMIT;
      else
         raw_in = product_ff[RAW_W-1:0];
   end

   // divides by 2^16, toward zero
   always_comb begin
      sq = sum_ff >>> 16;
      if (sum_ff < 0 && sum_ff[15:0] != '0)
         sq = sq + 1;
      filt_in = sq[FILT_W-1:0];
   end

   always_comb begin
      fq = filt_ff[w] >>> 16;
      if (filt_ff[w] < 0 && filt_ff[w][15:0] != '0)
         fq = fq + 1;
      speed_in = fq[SPEED_W-1:0];
      err_in   = ERR_W'(target_ff) - ERR_W'(speed_in);
   end

   // bring the Q.8 increment to ACC_FRAC_BITS
   always_comb begin
      if (SH >= 0) begin
         inc_scaled = sum_ff <<< PSH;
      end else begin
         inc_scaled = sum_ff >>> NSH;
         if (sum_ff < 0 && sum_ff[NSH-1:0] != '0)
            inc_scaled = inc_scaled + 1;
      end
   end

   assign lim_acc = $signed(ACC_W'({cfg.output_limit, {ACC_FRAC_BITS{1'b0}}}));
   assign lim_ext = (SUM_W+1)'(lim_acc);
   assign acc_sum = (SUM_W+1)'(acc_ff[w]) + (SUM_W+1)'(sum_ff);

   always_comb begin
      if (acc_sum >= lim_ext)
         acc_in = lim_acc;
      else if (acc_sum <= -lim_ext)
         acc_in = -lim_acc;
      else
         acc_in = acc_sum[ACC_W-1:0];
   end

   always_comb begin
      aq = acc_ff[w] >>> ACC_FRAC_BITS;
      if (acc_ff[w] < 0 && acc_ff[w][ACC_FRAC_BITS-1:0] != '0)
         aq = aq + 1;
      out_in = aq[OUT_W-1:0];
   end

   always_comb begin
      if (mode_ff) begin
         left_in      = DRV_W'(base_ff) - DRV_W'(out_ff[0]);
         right_in     = DRV_W'(base_ff) + DRV_W'(out_ff[1]);
         dir_left_in  = (left_in >= 0);
         dir_right_in = (right_in >= 0);
      end else begin
         left_in      = DRV_W'(out_ff[0]);
         right_in     = DRV_W'(out_ff[1]);
         dir_left_in  = (left_in > 0);
         dir_right_in = (right_in > 0);
      end
      mag_left_in  = MAG_W'((left_in < 0) ? -left_in : left_in);
      mag_right_in = MAG_W'((right_in < 0) ? -right_in : right_in);
   end

   always_comb begin
      sum_in = sum_ff;
      unique case (ctl.op)
         OP_LOAD_PROD: sum_in = product_ff[SUM_W-1:0];
         OP_ADD_PROD:  sum_in = sum_ff + product_ff[SUM_W-1:0];
         OP_INC_SCALE: sum_in = inc_scaled;
         default: ;
      endcase
   end

   // wheel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            prev_ff[i] <= '0;
            filt_ff[i] <= '0;
            perr_ff[i] <= '0;
            acc_ff[i]  <= '0;
         end
      end else begin
         unique case (ctl.op)
            OP_DIFF:       prev_ff[w] <= count_ff[w];
            OP_FILT_STORE: filt_ff[w] <= filt_in;
            OP_PERR:       perr_ff[w] <= err_ff;
            OP_ACC_CLAMP:  acc_ff[w]  <= acc_in;
            default: ;
         endcase
      end
   end

   // work registers, no reset
   always_ff @(posedge clock) begin
      product_ff <= product_in;
      sum_ff     <= sum_in;
      if (ctl.accept) begin
         count_ff[0] <= req_data.count_a[COUNT_WIDTH-1:0];
         count_ff[1] <= req_data.count_b[COUNT_WIDTH-1:0];
         target_ff   <= target_in;
         base_ff     <= req_data.base_drive;
         mode_ff     <= req_data.mode;
      end
      unique case (ctl.op)
         OP_DIFF:    delta_ff <= delta_in;
         OP_SAT:     raw_ff   <= raw_in;
         OP_ERROR: begin
            err_ff      <= err_in;
            speed_ff[w] <= speed_in;
         end
         OP_ACC_OUT: out_ff[w] <= out_in;
         default: ;
      endcase
   end

   // response register: loaded only when empty or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.op == OP_DRIVE && stat.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_DRIVE && stat.out_free) begin
         dir_left_ff  <= dir_left_in;
         mag_left_ff  <= mag_left_in;
         dir_right_ff <= dir_right_in;
         mag_right_ff <= mag_right_in;
         speed_a_ff   <= speed_ff[0];
         speed_b_ff   <= speed_ff[1];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.dir_left    = dir_left_ff;
   assign rsp_if.mag_left    = mag_left_ff;
   assign rsp_if.dir_right   = dir_right_ff;
   assign rsp_if.mag_right   = mag_right_ff;
   assign rsp_if.speed_a_now = speed_a_ff;
   assign rsp_if.speed_b_now = speed_b_ff;

`ifndef NO_ASSERTIONS
   ap_acc_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_ACC_CLAMP |=> (acc_ff[w] <= lim_acc && acc_ff[w] >= -lim_acc))
      else $error("accumulator outside the output limit after clamp");

   ap_speed_range: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_ERROR |=> speed_ff[w] != {1'b1, {(SPEED_W-1){1'b0}}})
      else $error("filtered speed reached the most negative code");

   ap_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == OP_DRIVE))
      else $error("response word raised outside the drive step");
`endif

endmodule

### rtl/core/dual_motor_speed_pi_loop.sv
// A request word is taken in the idle step; its response is loaded in the drive step.
// One word at a time runs the microcode program (13 steps per wheel
// through the one shared multiplier, plus idle and drive steps).
// The next word is taken while a response still waits; the drive step stalls until it drains.
// Reset (synchronous): registers to defaults, wheel state to zero, no clearing pass.
// Depends on dmpi_pkg, dmpi_if, dmpi_csr, dmpi_seq and dmpi_datapath.
module dual_motor_speed_pi_loop #(
   parameter int COUNT_WIDTH   = 32,
   parameter int ACC_FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   dmpi_req_if.sink   req_if,
   dmpi_rsp_if.source rsp_if,
   dmpi_csr_if.sink   csr_if
);
   import dmpi_pkg::*;

   cfg_type      cfg;
   ctl_type      ctl;
   stat_type     stat;
   req_data_type req_data;
   logic         seq_ready;

   assign req_data.count_a      = req_if.count_a;
   assign req_data.count_b      = req_if.count_b;
   assign req_data.target_speed = req_if.target_speed;
   assign req_data.base_drive   = req_if.base_drive;
   assign req_data.mode         = req_if.mode;
   assign req_if.ready          = seq_ready;

   dmpi_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   dmpi_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .stat      (stat),
      .req_ready (seq_ready),
      .ctl       (ctl)
   );

   dmpi_datapath #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .ACC_FRAC_BITS (ACC_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ctl      (ctl),
      .req_data (req_data),
      .stat     (stat),
      .rsp_if   (rsp_if)
   );

endmodule

### tb/testbench.sv
// Self-checking bench for dual_motor_speed_pi_loop: directed ticks, then random phases
// with sender gaps, receiver stalls and register changes. Prediction runs in the bench.
// Depends on dmpi_pkg, dmpi_if and the dual_motor_speed_pi_loop RTL.
module testbench;
   import dmpi_pkg::*;

   localparam int ACC_FRAC       = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DIRTY_CSR      = 1;
   localparam logic [63:0] RAW_SAT = 64'd32767 << 16;

   typedef struct {
      logic                      dir_left;
      logic [MAG_W-1:0]          mag_left;
      logic                      dir_right;
      logic [MAG_W-1:0]          mag_right;
      logic signed [SPEED_W-1:0] speed_a;
      logic signed [SPEED_W-1:0] speed_b;
   } drive_word_t;

   logic clock = 1'b0;
   logic reset;

   dmpi_req_if req_if();
   dmpi_rsp_if rsp_if();
   dmpi_csr_if csr_if();

   dual_motor_speed_pi_loop #(
      .COUNT_WIDTH(IN_COUNT_W),
      .ACC_FRAC_BITS(ACC_FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, one slot per wheel
   cfg_type               model_cfg;
   logic [IN_COUNT_W-1:0] last_count [2];
   longint                filt_q16 [2];
   longint                last_err [2];
   longint                pi_acc [2];

   req_data_type pending_ticks [$];
   drive_word_t  expected_drives [$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  rsp_hold_cycles = 0;
   int  fail_count = 0;
   int  quiet_cycles = 0;
   bit  req_taken = 1'b0;

   // random tick generator: segments of steady wheel speed and target
   logic [IN_COUNT_W-1:0]    gen_count [2];
   int                       seg_left = 0;
   int                       seg_delta [2];
   logic signed [TARGET_W-1:0] seg_target;
   logic signed [BASE_W-1:0]   seg_base;
   logic                       seg_mode;

   function automatic longint advance_wheel(input int w, input logic [IN_COUNT_W-1:0] count,
                                            input longint target, input longint dgain,
                                            input longint egain, output longint speed);
      logic [IN_COUNT_W-1:0] step;
      logic [63:0] mag;
      longint delta, raw, alpha, err, inc, lim;
      step = count - last_count[w];
      delta = $signed(step);
      last_count[w] = count;
      mag = (delta < 0) ? -delta : delta;
      mag = mag * model_cfg.speed_scale;
      if (mag > RAW_SAT)
         mag = RAW_SAT;
      raw = (delta < 0) ? -longint'(mag) : longint'(mag);
      if (model_cfg.filter_alpha > ALPHA_ONE)
         alpha = 65536;
      else
         alpha = model_cfg.filter_alpha;
      filt_q16[w] = (alpha * raw + (65536 - alpha) * filt_q16[w]) / 65536;
      speed = filt_q16[w] / 65536;
      err = target - speed;
      inc = dgain * (err - last_err[w]) + egain * err;
      last_err[w] = err;
      // gains are Q8.8; move the increment onto the accumulator's fraction
      if (ACC_FRAC >= 8)
         inc = inc * (longint'(1) << (ACC_FRAC - 8));
      else
         inc = inc / (longint'(1) << (8 - ACC_FRAC));
      lim = longint'(model_cfg.output_limit) << ACC_FRAC;
      pi_acc[w] = pi_acc[w] + inc;
      if (pi_acc[w] >= lim)
         pi_acc[w] = lim;
      else if (pi_acc[w] <= -lim)
         pi_acc[w] = -lim;
      return pi_acc[w] / (longint'(1) << ACC_FRAC);
   endfunction

   function automatic drive_word_t predict_drive(input req_data_type w);
      drive_word_t d;
      longint target, base, out_a, out_b, left, right, spd_a, spd_b;
      target = $signed(w.target_speed);
      base = $signed(w.base_drive);
      if (w.mode && ((target < 0) ? -target : target) < longint'(model_cfg.target_deadband))
         target = 0;
      out_a = advance_wheel(0, w.count_a, target, $signed(model_cfg.diff_gain_a),
                            $signed(model_cfg.err_gain_a), spd_a);
      out_b = advance_wheel(1, w.count_b, target, $signed(model_cfg.diff_gain_b),
                            $signed(model_cfg.err_gain_b), spd_b);
      if (w.mode) begin
         left = base - out_a;
         right = base + out_b;
         d.dir_left = (left >= 0);
         d.dir_right = (right >= 0);
      end else begin
         left = out_a;
         right = out_b;
         d.dir_left = (left > 0);
         d.dir_right = (right > 0);
      end
      d.mag_left = MAG_W'((left < 0) ? -left : left);
      d.mag_right = MAG_W'((right < 0) ? -right : right);
      d.speed_a = SPEED_W'(spd_a);
      d.speed_b = SPEED_W'(spd_b);
      return d;
   endfunction

   function automatic req_data_type next_random_tick();
      req_data_type w;
      int span, pick;
      if (seg_left == 0) begin
         seg_left = $urandom_range(40, 6);
         case ($urandom_range(3))
            0: span = 3;
            1: span = 40;
            2: span = 400;
            default: span = 6000;
         endcase
         seg_delta[0] = int'($urandom_range(2 * span)) - span;
         seg_delta[1] = int'($urandom_range(2 * span)) - span;
         case ($urandom_range(9))
            0: seg_target = TARGET_W'($urandom);
            1: seg_target = TARGET_W'(int'($urandom_range(24)) - 12);
            default: seg_target = TARGET_W'(int'($urandom_range(1600)) - 800);
         endcase
         case ($urandom_range(5))
            0: seg_base = -13'sd4096;
            1: seg_base = 13'sd4095;
            default: seg_base = BASE_W'(int'($urandom_range(4000)) - 2000);
         endcase
         seg_mode = $urandom_range(1);
      end
      seg_left--;
      pick = $urandom_range(99);
      if (pick < 4) begin
         gen_count[0] = $urandom;
         gen_count[1] = $urandom;
      end else begin
         gen_count[0] = gen_count[0] + seg_delta[0] + int'($urandom_range(6)) - 3;
         gen_count[1] = gen_count[1] + seg_delta[1] + int'($urandom_range(6)) - 3;
      end
      w.count_a = gen_count[0];
      w.count_b = gen_count[1];
      w.target_speed = (pick >= 4 && pick < 8) ? TARGET_W'($urandom) : seg_target;
      w.base_drive = (pick >= 90) ? BASE_W'($urandom) : seg_base;
      w.mode = (pick == 50) ? ~seg_mode : seg_mode;
      return w;
   endfunction

   task automatic push_tick(input logic [IN_COUNT_W-1:0] ca, input logic [IN_COUNT_W-1:0] cb,
                            input int target, input int base, input logic mode);
      req_data_type w;
      w.count_a = ca;
      w.count_b = cb;
      w.target_speed = TARGET_W'(target);
      w.base_drive = BASE_W'(base);
      w.mode = mode;
      gen_count[0] = ca;
      gen_count[1] = cb;
      pending_ticks.push_back(w);
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_if.valid || expected_drives.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!(csr_if.valid && csr_if.ready))
         @(posedge clock);
   endtask

   // dirty puts random bits above each register's width; the block must drop them
   task automatic program_regs(input cfg_type c, input bit dirty);
      logic [CSR_DATA_W-1:0] pad;
      pad = dirty ? $urandom : '0;
      write_reg(CSR_SPEED_SCALE, c.speed_scale);
      write_reg(CSR_FILTER_ALPHA, {pad[CSR_DATA_W-1:ALPHA_W], c.filter_alpha});
      write_reg(CSR_DIFF_GAIN_A, {pad[CSR_DATA_W-1:GAIN_W], c.diff_gain_a});
      write_reg(CSR_ERR_GAIN_A, {pad[CSR_DATA_W-1:GAIN_W], c.err_gain_a});
      write_reg(CSR_DIFF_GAIN_B, {pad[CSR_DATA_W-1:GAIN_W], c.diff_gain_b});
      write_reg(CSR_ERR_GAIN_B, {pad[CSR_DATA_W-1:GAIN_W], c.err_gain_b});
      write_reg(CSR_OUTPUT_LIMIT, {pad[CSR_DATA_W-1:LIMIT_W], c.output_limit});
      write_reg(CSR_DEADBAND, {pad[CSR_DATA_W-1:DBAND_W], c.target_deadband});
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_phase(input int ticks, input int idle_pct, input int stall_pct,
                            input int hold);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      rsp_hold_cycles = hold;
      repeat (ticks) pending_ticks.push_back(next_random_tick());
      wait_drained();
   endtask

   // request driver
   always @(negedge clock) begin
      req_data_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = pending_ticks.pop_front();
            req_if.valid <= 1'b1;
            req_if.count_a <= w.count_a;
            req_if.count_b <= w.count_b;
            req_if.target_speed <= w.target_speed;
            req_if.base_drive <= w.base_drive;
            req_if.mode <= w.mode;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response receiver; a hold keeps ready low so the block backs up
   always @(negedge clock) begin
      if (reset || rsp_hold_cycles > 0)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0)
         rsp_hold_cycles = rsp_hold_cycles - 1;
   end

   // monitor: predicts on each accepted tick, checks each accepted drive word
   always @(posedge clock) begin
      req_data_type w;
      drive_word_t want;
      bit rsp_fire, csr_fire;
      if (reset) begin
         model_cfg = '{speed_scale: RST_SPEED_SCALE, filter_alpha: RST_FILTER_ALPHA,
                       diff_gain_a: RST_DIFF_GAIN_A, err_gain_a: RST_ERR_GAIN_A,
                       diff_gain_b: RST_DIFF_GAIN_B, err_gain_b: RST_ERR_GAIN_B,
                       output_limit: RST_OUTPUT_LIMIT, target_deadband: RST_DEADBAND};
         for (int i = 0; i < 2; i++) begin
            last_count[i] = '0;
            filt_q16[i] = 0;
            last_err[i] = 0;
            pi_acc[i] = 0;
         end
         req_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         rsp_fire = rsp_if.valid && rsp_if.ready;
         csr_fire = csr_if.valid && csr_if.ready;
         if (csr_fire) begin
            case (csr_index_type'(csr_if.index))
               CSR_SPEED_SCALE:  model_cfg.speed_scale = csr_if.data;
               CSR_FILTER_ALPHA: model_cfg.filter_alpha = csr_if.data[ALPHA_W-1:0];
               CSR_DIFF_GAIN_A:  model_cfg.diff_gain_a = csr_if.data[GAIN_W-1:0];
               CSR_ERR_GAIN_A:   model_cfg.err_gain_a = csr_if.data[GAIN_W-1:0];
               CSR_DIFF_GAIN_B:  model_cfg.diff_gain_b = csr_if.data[GAIN_W-1:0];
               CSR_ERR_GAIN_B:   model_cfg.err_gain_b = csr_if.data[GAIN_W-1:0];
               CSR_OUTPUT_LIMIT: model_cfg.output_limit = csr_if.data[LIMIT_W-1:0];
               CSR_DEADBAND:     model_cfg.target_deadband = csr_if.data[DBAND_W-1:0];
               default: ;
            endcase
         end
         if (req_taken) begin
            w.count_a = req_if.count_a;
            w.count_b = req_if.count_b;
            w.target_speed = req_if.target_speed;
            w.base_drive = req_if.base_drive;
            w.mode = req_if.mode;
            expected_drives.push_back(predict_drive(w));
         end
         if (rsp_fire) begin
            if (expected_drives.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected drive word: dirL=%0d magL=%0d dirR=%0d magR=%0d spdA=%0d spdB=%0d",
                           rsp_if.dir_left, rsp_if.mag_left, rsp_if.dir_right,
                           rsp_if.mag_right, rsp_if.speed_a_now, rsp_if.speed_b_now);
            end else begin
               want = expected_drives.pop_front();
               if (rsp_if.dir_left !== want.dir_left || rsp_if.mag_left !== want.mag_left ||
                   rsp_if.dir_right !== want.dir_right || rsp_if.mag_right !== want.mag_right ||
                   rsp_if.speed_a_now !== want.speed_a ||
                   rsp_if.speed_b_now !== want.speed_b) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("drive word mismatch at %0t", $realtime);
                     $display("  expected dirL=%0d magL=%0d dirR=%0d magR=%0d spdA=%0d spdB=%0d",
                              want.dir_left, want.mag_left, want.dir_right, want.mag_right,
                              want.speed_a, want.speed_b);
                     $display("  actual   dirL=%0d magL=%0d dirR=%0d magR=%0d spdA=%0d spdB=%0d",
                              rsp_if.dir_left, rsp_if.mag_left, rsp_if.dir_right,
                              rsp_if.mag_right, rsp_if.speed_a_now, rsp_if.speed_b_now);
                  end
               end
            end
         end
         if (req_taken || rsp_fire || csr_fire) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
               $display("** dual_motor_speed_pi_loop: FAILED **");
               $finish;
            end
         end
      end
   end

   initial begin
      cfg_type cfg;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.count_a = '0;
      req_if.count_b = '0;
      req_if.target_speed = '0;
      req_if.base_drive = '0;
      req_if.mode = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      gen_count[0] = '0;
      gen_count[1] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ticks at reset register values
      push_tick(0, 0, 0, 0, 1'b1);            // base mode, drive exactly zero
      push_tick(0, 0, 0, 0, 1'b0);            // plain mode, output zero
      push_tick(1000, -1000, 100, 0, 1'b0);   // first movement
      push_tick(1100, -1100, 100, 0, 1'b0);
      push_tick(32'h7FFF_FFFF, 32'h8000_0000, 32767, 4095, 1'b1);
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, -32768, -4096, 1'b1);  // counter wrap
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, 4, 300, 1'b1);         // inside deadband
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, -4, 300, 1'b1);
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, 5, 300, 1'b1);         // deadband edge
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, -5, 300, 1'b1);
      push_tick(32'h8000_0005, 32'h7FFF_FFFA, 4, 300, 1'b0);         // no deadband in plain
      push_tick(32'h8000_000F, 32'h7FFF_FFF0, -1, -1, 1'b1);
      for (int i = 1; i <= 4; i++)
         push_tick(gen_count[0] + 50, gen_count[1] + 50, 2000, 4095, 1'b1);
      for (int i = 1; i <= 4; i++)
         push_tick(gen_count[0] - 20, gen_count[1] - 20, -32768, 0, 1'b0);
      push_tick(gen_count[0], gen_count[1], 0, -4096, 1'b1);
      push_tick(gen_count[0] - 32'h7000_0000, gen_count[1] + 32'h7000_0000, 0, 0, 1'b0);
      push_tick(32'hFFFF_FFFF, 32'h0000_0001, 32767, 4095, 1'b0);
      wait_drained();

      // typical loop settings, no gaps
      cfg = '{speed_scale: 32'd13107, filter_alpha: 17'd13107, diff_gain_a: 16'sd1792,
              err_gain_a: 16'sd64, diff_gain_b: 16'sd1920, err_gain_b: 16'sd32,
              output_limit: 12'd1220, target_deadband: 8'd5};
      program_regs(cfg, 1'b0);
      run_phase(150, 0, 0, 0);

      // upper extremes, alpha above one, sender mostly idle
      cfg = '{speed_scale: 32'hFFFF_FFFF, filter_alpha: 17'h1_FFFF, diff_gain_a: 16'sh7FFF,
              err_gain_a: 16'sh8000, diff_gain_b: 16'sh8000, err_gain_b: 16'sh7FFF,
              output_limit: 12'd4095, target_deadband: 8'd255};
      program_regs(cfg, 1'b0);
      run_phase(140, 79, 0, 0);

      // alpha of exactly one; receiver mostly stalling after a long hold
      cfg = '{speed_scale: 32'd32768, filter_alpha: ALPHA_ONE, diff_gain_a: -16'sd256,
              err_gain_a: 16'sd300, diff_gain_b: 16'sd256, err_gain_b: -16'sd300,
              output_limit: 12'd2047, target_deadband: 8'd12};
      program_regs(cfg, 1'b0);
      run_phase(140, 0, 79, 400);

      // random settings with junk above each register, light gaps on both sides
      cfg.speed_scale = $urandom_range(200000);
      cfg.filter_alpha = $urandom_range(70000);
      cfg.diff_gain_a = GAIN_W'(int'($urandom_range(4000)) - 2000);
      cfg.err_gain_a = GAIN_W'(int'($urandom_range(1000)) - 500);
      cfg.diff_gain_b = GAIN_W'(int'($urandom_range(4000)) - 2000);
      cfg.err_gain_b = GAIN_W'(int'($urandom_range(1000)) - 500);
      cfg.output_limit = $urandom_range(4095, 200);
      cfg.target_deadband = $urandom_range(40);
      program_regs(cfg, DIRTY_CSR);
      run_phase(150, 8, 8, 0);

      // lower extremes
      cfg = '{speed_scale: 32'd0, filter_alpha: 17'd0, diff_gain_a: 16'sh8000,
              err_gain_a: -16'sd1, diff_gain_b: 16'sd0, err_gain_b: 16'sh8000,
              output_limit: 12'd0, target_deadband: 8'd0};
      program_regs(cfg, DIRTY_CSR);
      run_phase(50, 0, 0, 0);

      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_drives.size() == 0) begin
         $display("** dual_motor_speed_pi_loop: PASSED **");
      end else begin
         if (expected_drives.size() != 0)
            $display("%0d drive words never arrived", expected_drives.size());
         $display("** dual_motor_speed_pi_loop: FAILED **");
      end
      $finish;
   end

endmodule

### dual_motor_speed_pi_loop.f
rtl/core/dmpi_pkg.sv
rtl/core/dmpi_if.sv
rtl/core/dmpi_csr.sv
rtl/core/dmpi_seq.sv
rtl/core/dmpi_datapath.sv
rtl/core/dual_motor_speed_pi_loop.sv
tb/testbench.sv
